[rtl/core/dks_pkg.sv]
// Shared constants, types and state codes of the descending key sorter.
`timescale 1ns / 1ps
package dks_pkg;

  localparam int DEPTH   = 16;                 // items kept per set
  localparam int CNT_W   = $clog2(DEPTH + 1);  // holds 0..DEPTH
  localparam int IDX_W   = $clog2(DEPTH);      // store index
  localparam int QDEPTH  = 2;                  // front-to-back queue entries
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int KEY_W   = 32;
  localparam int TAG_W   = 8;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [KEY_W-1:0] volume;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             drop;   // store was full when this item arrived
  } dks_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } dks_state_t;

endpackage

[rtl/core/descending_key_sort_core.sv]
// Top level of the descending key sorter: front end, queue and back end.
`timescale 1ns / 1ps
// Operation: a set of n items (n <= DEPTH) is loaded from the queue, sorted in
//   n phases and emitted from the head of the store; the back end reads no
//   new item from the queue until it has emitted the last result of the set.
// Throughput: set by the single compare-swap network (one phase per cycle) and
//   the one-result-per-cycle drain of the store while results are being taken.
// Reset: rst_n low clears the fill counts, overflow flag, queue and result valid
//   bit; item store and result data are not cleared, meaningless until loaded.
module descending_key_sort_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // input queue side
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [dks_pkg::KEY_W-1:0] in_volume,
  input  logic [dks_pkg::TAG_W-1:0] in_tag,
  input  logic                      in_last,
  // result queue side
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [dks_pkg::KEY_W-1:0] out_sorted_volume,
  output logic [dks_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_final_res,
  output logic                      out_overflow
);
  import dks_pkg::*;

  logic      q_wr, q_full, q_rd, q_valid;
  dks_item_t q_wr_item, q_rd_item;

  // The front end tags each transfer as kept or dropped, so the back end
  // never has to look at the input side while it sorts or drains.
  dks_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_volume (in_volume),
    .in_tag    (in_tag),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_wr_item (q_wr_item)
  );

  // Items wait here while the back end is busy sorting or emitting.
  dks_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd      (q_rd),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  // Stable descending sort: odd-even transposition that swaps only on a
  // strictly smaller earlier key, so equal keys keep arrival order.
  dks_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_rd_item),
    .q_rd              (q_rd),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_sorted_volume (out_sorted_volume),
    .out_sorted_tag    (out_sorted_tag),
    .out_final_res     (out_final_res),
    .out_overflow      (out_overflow)
  );

  assign in_full = q_full;

endmodule

[rtl/core/dks_front.sv]
// Front end: accepts items and marks those that no longer fit in the store.
`timescale 1ns / 1ps
module dks_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  input  logic [dks_pkg::KEY_W-1:0] in_volume,
  input  logic [dks_pkg::TAG_W-1:0] in_tag,
  input  logic                      in_last,
  input  logic                      q_full,
  output logic                      q_wr,
  output dks_pkg::dks_item_t        q_wr_item
);
  import dks_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop;

  assign drop = (cnt_r == CNT_W'(DEPTH));
  assign q_wr = in_push && !q_full;

  always_comb begin
    q_wr_item.volume = in_volume;
    q_wr_item.tag    = in_tag;
    q_wr_item.last   = in_last;
    q_wr_item.drop   = drop;
  end

  // Mirrors the back end's fill level so drops are decided at the door.
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_wr) begin
      if (in_last) begin
        cnt_nxt = '0;
      end else if (!drop) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/dks_queue.sv]
// Short FIFO that decouples the front end from the sorting back end.
`timescale 1ns / 1ps
module dks_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  dks_pkg::dks_item_t wr_item,
  output logic               full,
  input  logic               rd,
  output logic               valid,
  output dks_pkg::dks_item_t rd_item
);
  import dks_pkg::*;

  dks_item_t          mem_r [QDEPTH];
  logic [QIDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign rd_item = mem_r[rd_ptr_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QIDX_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QIDX_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/core/dks_back.sv]
// Back end: item store, odd-even transposition sorter and result register.
`timescale 1ns / 1ps
module dks_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  dks_pkg::dks_item_t        q_item,
  output logic                      q_rd,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [dks_pkg::KEY_W-1:0] out_sorted_volume,
  output logic [dks_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_final_res,
  output logic                      out_overflow
);
  import dks_pkg::*;

  dks_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] phase_r, phase_nxt;
  logic             flag_r, flag_nxt;
  logic             take;

  logic [KEY_W-1:0] key_r [DEPTH];
  logic [KEY_W-1:0] key_nxt [DEPTH];
  logic [TAG_W-1:0] tag_r [DEPTH];
  logic [TAG_W-1:0] tag_nxt [DEPTH];

  logic             ovalid_r, ovalid_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic [TAG_W-1:0] otag_r, otag_nxt;
  logic             ofinal_r, ofinal_nxt;
  logic             oovf_r, oovf_nxt;

  // Control: collect, sort for cnt phases, then drain from the head.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    q_rd      = 1'b0;
    take      = 1'b0;
    case (state_r)
      ST_LOAD: begin
        q_rd = q_valid;
        if (q_valid) begin
          if (q_item.drop) begin
            flag_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (q_item.last) begin
            state_nxt = ST_SORT;
            phase_nxt = '0;
          end
        end
      end
      ST_SORT: begin
        phase_nxt = phase_r + CNT_W'(1);
        if (phase_r == cnt_r - CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        take = !ovalid_r || out_pop;
        if (take) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_LOAD;
            flag_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Store: write on load, compare-swap disjoint pairs on sort, shift on emit.
  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (q_rd && !q_item.drop) begin
      key_nxt[cnt_r[IDX_W-1:0]] = q_item.volume;
      tag_nxt[cnt_r[IDX_W-1:0]] = q_item.tag;
    end
    if (state_r == ST_SORT) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if ((i[0] == phase_r[0]) && (CNT_W'(i + 1) < cnt_r) && (key_r[i] < key_r[i + 1])) begin
          key_nxt[i]     = key_r[i + 1];
          tag_nxt[i]     = tag_r[i + 1];
          key_nxt[i + 1] = key_r[i];
          tag_nxt[i + 1] = tag_r[i];
        end
      end
    end
    if (take) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        key_nxt[i] = key_r[i + 1];
        tag_nxt[i] = tag_r[i + 1];
      end
    end
  end

  // Result register.
  always_comb begin
    ovalid_nxt = ovalid_r;
    okey_nxt   = okey_r;
    otag_nxt   = otag_r;
    ofinal_nxt = ofinal_r;
    oovf_nxt   = oovf_r;
    if (take) begin
      ovalid_nxt = 1'b1;
      okey_nxt   = key_r[0];
      otag_nxt   = tag_r[0];
      ofinal_nxt = (cnt_r == CNT_W'(1));
      oovf_nxt   = flag_r;
    end else if (out_pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      phase_r  <= '0;
      flag_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      flag_r   <= flag_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    tag_r    <= tag_nxt;
    okey_r   <= okey_nxt;
    otag_r   <= otag_nxt;
    ofinal_r <= ofinal_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_empty         = !ovalid_r;
  assign out_sorted_volume = okey_r;
  assign out_sorted_tag    = otag_r;
  assign out_final_res     = ofinal_r;
  assign out_overflow      = oovf_r;

endmodule

[rtl/core/dks_checker.sv]
// Port-level checks of the descending key sorter, bound to the top level.
`timescale 1ns / 1ps
module dks_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_push,
  input logic                      in_full,
  input logic                      out_pop,
  input logic                      out_empty,
  input logic [dks_pkg::KEY_W-1:0] out_sorted_volume,
  input logic [dks_pkg::TAG_W-1:0] out_sorted_tag,
  input logic                      out_final_res,
  input logic                      out_overflow
);
  import dks_pkg::*;

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A waiting result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_sorted_volume) && $stable(out_sorted_tag)))
    else $error("result changed while waiting");

  // Within a run the next result follows at once, never larger, same flag.
  a_descend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_final_res) |=>
      (!out_empty && (out_sorted_volume <= $past(out_sorted_volume))
       && (out_overflow == $past(out_overflow))))
    else $error("run not descending or broken");

  // Full only rises after a transfer in.
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_full && !in_push) |=> !in_full)
    else $error("full rose without a transfer");

endmodule

bind descending_key_sort_core dks_checker u_dks_checker (.*);
